// ===== src/wwfe_pkg.sv =====
// ----------------------------------------------------------------------------
// wwfe_pkg
// shared constants and codes for the windowed watchdog with fault escalation
// ----------------------------------------------------------------------------
package wwfe_pkg;

    localparam int unsigned COUNT_WIDTH_DEF = 16;
    localparam int unsigned WIN_WIDTH       = 16;
    localparam int unsigned CFG_IDX_WIDTH   = 2;
    localparam int unsigned CODE_WIDTH      = 2;
    localparam int unsigned RCNT_WIDTH      = 2;

    localparam logic [WIN_WIDTH-1:0] WIN_MIN_RST = WIN_WIDTH'(1);
    localparam logic [WIN_WIDTH-1:0] WIN_MAX_RST = WIN_WIDTH'(10);

    // configuration register indexes
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_WIN_MIN = 2'd0,
        CFG_WIN_MAX = 2'd1
    } t_cfg_idx;

    // error codes carried by a heartbeat
    typedef enum logic [CODE_WIDTH-1:0] {
        ERR_NONE     = 2'd0,
        ERR_TIMEOUT  = 2'd1,
        ERR_OVERHEAT = 2'd2,
        ERR_UNKNOWN  = 2'd3
    } t_err_code;

endpackage

// ===== src/wwfe_req_if.sv =====
// ----------------------------------------------------------------------------
// wwfe_req_if
// request channel: one poll tick with an optional heartbeat
// ----------------------------------------------------------------------------
interface wwfe_req_if;
    logic                                valid;
    logic                                ready;
    logic                                message_valid;
    logic                                error_detected;
    logic [wwfe_pkg::CODE_WIDTH-1:0]     error_code;

    modport source (output valid, output message_valid, output error_detected,
                    output error_code, input ready);
    modport sink   (input valid, input message_valid, input error_detected,
                    input error_code, output ready);
endinterface

// ===== src/wwfe_rsp_if.sv =====
// ----------------------------------------------------------------------------
// wwfe_rsp_if
// result channel: restart orders and status for one tick
// ----------------------------------------------------------------------------
interface wwfe_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [wwfe_pkg::RCNT_WIDTH-1:0]     restart_count;
    logic                                timeout_restart;
    logic                                early_restart;
    logic                                fault_restart;
    logic                                cooling_on;
    logic                                message_ack;

    modport source (output valid, output restart_count, output timeout_restart,
                    output early_restart, output fault_restart, output cooling_on,
                    output message_ack, input ready);
    modport sink   (input valid, input restart_count, input timeout_restart,
                    input early_restart, input fault_restart, input cooling_on,
                    input message_ack, output ready);
endinterface

// ===== src/window_watchdog_fault_escalation.sv =====
// ----------------------------------------------------------------------------
// window_watchdog_fault_escalation
// windowed watchdog: orders controller restarts on timeout, early heartbeat
// or reported fault, with a cooling flag that escalates repeated overheating
// ----------------------------------------------------------------------------
// a result is registered and appears in the cycle after its request is accepted
// throughput: one request per cycle while the output is not stalled; the tick counter
//   and cooling flag update as a request is accepted, the result sits in one output register
// ready is high whenever the output register is empty or being drained
// reset (synchronous, active low): window min 1, window max 10, counter 0,
//   cooling off, output register empty
module window_watchdog_fault_escalation #(
    parameter int unsigned COUNT_WIDTH = wwfe_pkg::COUNT_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [wwfe_pkg::CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [wwfe_pkg::WIN_WIDTH-1:0]     i_cfg_data,
    wwfe_req_if.sink                           i_req,
    wwfe_rsp_if.source                         o_rsp
);
    import wwfe_pkg::*;

    // compare width covers both the counter and the window registers
    localparam int unsigned CMP_WIDTH =
        (COUNT_WIDTH > WIN_WIDTH) ? COUNT_WIDTH : WIN_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_SAT = {COUNT_WIDTH{1'b1}};

    // window configuration
    logic [WIN_WIDTH-1:0]   r_win_min;
    logic [WIN_WIDTH-1:0]   r_win_max;

    // watchdog state
    logic [COUNT_WIDTH-1:0] r_elapsed, n_elapsed;
    logic                   r_cooling, n_cooling;

    // output register
    logic                   r_out_valid;
    logic [RCNT_WIDTH-1:0]  r_restart_count, n_restart_count;
    logic                   r_timeout, n_timeout;
    logic                   r_early, n_early;
    logic                   r_fault, n_fault;
    logic                   r_ack;

    logic                   req_fire;
    logic                   msg;
    logic                   err;
    logic                   cool_mid;
    t_err_code              code;

    // a new request is taken whenever the output register frees up this cycle
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign req_fire    = i_req.valid && i_req.ready;

    assign msg  = i_req.message_valid;
    assign err  = i_req.message_valid && i_req.error_detected;
    assign code = t_err_code'(i_req.error_code);

    always_comb begin
        // window rules use the count as seen at the start of the tick
        n_timeout = CMP_WIDTH'(r_elapsed) > CMP_WIDTH'(r_win_max);
        n_early   = msg && (CMP_WIDTH'(r_elapsed) < CMP_WIDTH'(r_win_min));

        // cooling after the window restarts have cleared it
        cool_mid = r_cooling && !n_timeout && !n_early;

        n_fault   = 1'b0;
        n_cooling = cool_mid;
        if (err) begin
            unique case (code)
                ERR_TIMEOUT, ERR_UNKNOWN: begin
                    n_fault   = 1'b1;
                    n_cooling = 1'b0;
                end
                ERR_OVERHEAT: begin
                    // first overheat turns cooling on, a repeat escalates
                    n_fault   = cool_mid;
                    n_cooling = !cool_mid;
                end
                default: begin
                    n_cooling = cool_mid;
                end
            endcase
        end

        n_restart_count = RCNT_WIDTH'({1'b0, n_timeout}) + RCNT_WIDTH'({1'b0, n_early})
                        + RCNT_WIDTH'({1'b0, n_fault});

        // window restarts on any heartbeat or timeout, else count up and saturate
        if (n_timeout || msg) begin
            n_elapsed = COUNT_ONE;
        end else if (r_elapsed != COUNT_SAT) begin
            n_elapsed = r_elapsed + COUNT_ONE;
        end else begin
            n_elapsed = r_elapsed;
        end
    end

    // configuration writes, unused index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_min <= WIN_MIN_RST;
            r_win_max <= WIN_MAX_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_WIN_MIN) begin
                r_win_min <= i_cfg_data;
            end
            if (i_cfg_idx == CFG_WIN_MAX) begin
                r_win_max <= i_cfg_data;
            end
        end
    end

    // watchdog state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed   <= '0;
            r_cooling   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (req_fire) begin
                r_elapsed   <= n_elapsed;
                r_cooling   <= n_cooling;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted request
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_restart_count <= n_restart_count;
            r_timeout       <= n_timeout;
            r_early         <= n_early;
            r_fault         <= n_fault;
            r_ack           <= msg;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.restart_count   = r_restart_count;
    assign o_rsp.timeout_restart = r_timeout;
    assign o_rsp.early_restart   = r_early;
    assign o_rsp.fault_restart   = r_fault;
    assign o_rsp.cooling_on      = r_cooling;
    assign o_rsp.message_ack     = r_ack;

    // restart count always matches the individual restart flags
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.restart_count ==
            RCNT_WIDTH'({1'b0, o_rsp.timeout_restart}) +
            RCNT_WIDTH'({1'b0, o_rsp.early_restart}) +
            RCNT_WIDTH'({1'b0, o_rsp.fault_restart})))
        else $error("restart count disagrees with restart flags");

    // a fault restart always leaves cooling off
    a_fault_clears_cooling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.fault_restart) |-> !o_rsp.cooling_on)
        else $error("cooling still on after fault restart");

    // heartbeat restarts the window
    a_msg_restarts_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_fire && msg) |=> (r_elapsed == COUNT_ONE))
        else $error("window not restarted after heartbeat");

    // early and fault restarts need a heartbeat
    a_no_msg_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.message_ack) |-> (!o_rsp.early_restart && !o_rsp.fault_restart))
        else $error("heartbeat restart without heartbeat");

endmodule

// ===== tb/sv/window_watchdog_fault_escalation_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_watchdog_fault_escalation_tb
// drives poll ticks with random heartbeats and faults into the watchdog,
// predicts every tick's restart orders and cooling state in the bench and
// checks each result field by field, across several window settings
// ----------------------------------------------------------------------------
module window_watchdog_fault_escalation_tb;
    import wwfe_pkg::*;

    localparam int unsigned COUNT_W      = COUNT_WIDTH_DEF;
    localparam int unsigned RUN_LIMIT_NS = 5_000_000;
    localparam int unsigned PHASE_TICKS  = 92;
    localparam int unsigned MAX_PRINTS   = 100;

    // register indexes the block does not decode
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_SPARE_B = 2'd3;

    // one poll tick as seen on the request channel
    typedef struct packed {
        logic      message_valid;
        logic      error_detected;
        t_err_code error_code;
    } t_tick;

    // what the watchdog orders for one tick
    typedef struct packed {
        logic [RCNT_WIDTH-1:0] restart_count;
        logic                  timeout_restart;
        logic                  early_restart;
        logic                  fault_restart;
        logic                  cooling_on;
        logic                  message_ack;
    } t_verdict;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_WIDTH-1:0] i_cfg_idx;
    logic [WIN_WIDTH-1:0]     i_cfg_data;

    wwfe_req_if req_ch ();
    wwfe_rsp_if rsp_ch ();

    window_watchdog_fault_escalation #(
        .COUNT_WIDTH (COUNT_W)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source)
    );

    // watchdog shadow state, kept in step with accepted requests
    logic [WIN_WIDTH-1:0] win_min;
    logic [WIN_WIDTH-1:0] win_max;
    logic [COUNT_W-1:0]   elapsed;
    logic                 cooling;

    t_tick    tick_q[$];      // ticks waiting for the driver
    t_verdict verdict_q[$];   // predicted results not yet returned

    int  ticks_queued   = 0;
    int  ticks_taken    = 0;
    int  results_seen   = 0;
    int  mismatch_count = 0;
    bit  req_fire       = 1'b0;  // request accepted at the last rising edge
    bit  full_rate      = 1'b0;  // no sender gaps, no receiver stalls

    // sender burst shaping
    int  burst_left = 0;
    int  gap_left   = 0;

    // receiver stall pattern
    logic [15:0] stall_pat  = '1;
    logic [3:0]  pat_pos    = '0;
    int          pat_life   = 0;
    int          stall_mode = 0;

    // ------------------------------------------------------------------------
    // clock and run limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // predictor: one poll tick through the watchdog rules, in rule order
    // ------------------------------------------------------------------------
    function automatic t_verdict watchdog_step(input t_tick t);
        t_verdict v;
        logic [RCNT_WIDTH-1:0] n;
        v = '0;
        n = '0;
        // window maximum exceeded, judged on the count at tick start
        if (elapsed > win_max) begin
            v.timeout_restart = 1'b1;
            cooling = 1'b0;
            n = n + 1'b1;
        end
        if (t.message_valid) begin
            // heartbeat too soon
            if (elapsed < win_min) begin
                v.early_restart = 1'b1;
                cooling = 1'b0;
                n = n + 1'b1;
            end
            if (t.error_detected) begin
                case (t.error_code)
                    ERR_TIMEOUT, ERR_UNKNOWN: v.fault_restart = 1'b1;
                    // first overheat starts cooling, a second one escalates
                    ERR_OVERHEAT: begin
                        if (cooling) v.fault_restart = 1'b1;
                        else cooling = 1'b1;
                    end
                    default: ;
                endcase
                if (v.fault_restart) begin
                    cooling = 1'b0;
                    n = n + 1'b1;
                end
            end
        end
        // a message or a timeout restarts the window, otherwise count up
        // and hold at the top
        if (v.timeout_restart || t.message_valid) elapsed = COUNT_W'(1);
        else if (elapsed != '1) elapsed = elapsed + 1'b1;
        v.restart_count = n;
        v.cooling_on    = cooling;
        v.message_ack   = t.message_valid;
        return v;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // monitor: sample both channels at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_verdict want;
        t_tick    seen;
        req_fire = 1'b0;
        if (i_rst_n) begin
            // check the result first: a request taken at this edge cannot
            // have its result out before the next edge
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("result with no tick waiting", 1, 0);
                end else begin
                    want = verdict_q.pop_front();
                    if (rsp_ch.restart_count !== want.restart_count)
                        report_mismatch("restart_count", int'(rsp_ch.restart_count),
                                        int'(want.restart_count));
                    if (rsp_ch.timeout_restart !== want.timeout_restart)
                        report_mismatch("timeout_restart", int'(rsp_ch.timeout_restart),
                                        int'(want.timeout_restart));
                    if (rsp_ch.early_restart !== want.early_restart)
                        report_mismatch("early_restart", int'(rsp_ch.early_restart),
                                        int'(want.early_restart));
                    if (rsp_ch.fault_restart !== want.fault_restart)
                        report_mismatch("fault_restart", int'(rsp_ch.fault_restart),
                                        int'(want.fault_restart));
                    if (rsp_ch.cooling_on !== want.cooling_on)
                        report_mismatch("cooling_on", int'(rsp_ch.cooling_on),
                                        int'(want.cooling_on));
                    if (rsp_ch.message_ack !== want.message_ack)
                        report_mismatch("message_ack", int'(rsp_ch.message_ack),
                                        int'(want.message_ack));
                end
                results_seen++;
            end
            if (req_ch.valid && req_ch.ready) begin
                seen.message_valid  = req_ch.message_valid;
                seen.error_detected = req_ch.error_detected;
                seen.error_code     = t_err_code'(req_ch.error_code);
                verdict_q.push_back(watchdog_step(seen));
                ticks_taken++;
                req_fire = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // driver: bursts of requests with random gaps, changes on falling edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : driver
        t_tick nxt;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (req_ch.valid && !req_fire) begin
            // request still waiting for ready, hold it
        end else if (gap_left > 0 && !full_rate) begin
            gap_left--;
            req_ch.valid <= 1'b0;
        end else if (tick_q.size() > 0) begin
            nxt = tick_q.pop_front();
            req_ch.valid          <= 1'b1;
            req_ch.message_valid  <= nxt.message_valid;
            req_ch.error_detected <= nxt.error_detected;
            req_ch.error_code     <= nxt.error_code;
            burst_left--;
            if (burst_left <= 0) begin
                // now and then a long stretch with no gaps at all
                if ($urandom_range(0, 3) == 0) begin
                    gap_left   = 0;
                    burst_left = $urandom_range(20, 60);
                end else begin
                    gap_left   = $urandom_range(1, 8);
                    burst_left = $urandom_range(1, 12);
                end
            end
        end else begin
            req_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // receiver: ready follows a rotating stall pattern that changes now and then
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : receiver
        if (pat_life == 0) begin
            stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0:       stall_pat = '1;                          // never stall
                1:       stall_pat = 16'($urandom) | 16'h1;       // even mix
                default: stall_pat = 16'($urandom & $urandom) | 16'h1;  // mostly stalled
            endcase
            pat_life = $urandom_range(16, 96);
        end
        pat_life--;
        rsp_ch.ready <= full_rate | stall_pat[pat_pos];
        pat_pos = pat_pos + 1'b1;
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_tick(input logic msg, input logic err, input t_err_code code);
        t_tick t;
        t.message_valid  = msg;
        t.error_detected = err;
        t.error_code     = code;
        tick_q.push_back(t);
        ticks_queued++;
    endtask

    // wait until every request is taken and every result checked
    task automatic wait_idle();
        do @(posedge i_clk);
        while (ticks_taken != ticks_queued || verdict_q.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    // write both window registers, optionally a write to an undecoded index
    task automatic set_window(input logic [WIN_WIDTH-1:0] lo,
                              input logic [WIN_WIDTH-1:0] hi, input bit junk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_WIN_MIN;
        i_cfg_data <= lo;
        win_min     = lo;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_WIN_MAX;
        i_cfg_data <= hi;
        win_max     = hi;
        if (junk) begin
            @(negedge i_clk);
            i_cfg_idx  <= $urandom_range(0, 1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B;
            i_cfg_data <= WIN_WIDTH'($urandom);
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // idle ticks then a heartbeat, repeated; idle spans reach three past a window maximum below 40, else 20
    task automatic queue_heartbeat_runs(input int n_ticks);
        int made;
        int hi;
        int idle_span;
        int pick;
        made = 0;
        while (made < n_ticks) begin
            hi = (win_max < 40) ? int'(win_max) + 3 : 20;
            idle_span = $urandom_range(0, hi);
            repeat (idle_span) begin
                // mostly quiet ticks, some with a stray error flag
                if ($urandom_range(0, 9) == 0)
                    push_tick(1'b0, 1'b1, t_err_code'($urandom_range(0, 3)));
                else
                    push_tick(1'b0, 1'b0, t_err_code'($urandom_range(0, 3)));
                made++;
            end
            pick = $urandom_range(0, 99);
            if (pick < 30)      push_tick(1'b1, 1'b0, t_err_code'($urandom_range(0, 3)));
            else if (pick < 38) push_tick(1'b1, 1'b1, ERR_NONE);
            else if (pick < 70) push_tick(1'b1, 1'b1, ERR_OVERHEAT);
            else if (pick < 85) push_tick(1'b1, 1'b1, ERR_TIMEOUT);
            else if (pick < 95) push_tick(1'b1, 1'b1, ERR_UNKNOWN);
            else push_tick(1'b1, 1'($urandom), t_err_code'($urandom_range(0, 3)));
            made++;
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int p;
        logic [WIN_WIDTH-1:0] lo;
        logic [WIN_WIDTH-1:0] hi;

        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = CFG_WIN_MIN;
        i_cfg_data            = '0;
        req_ch.valid          = 1'b0;
        req_ch.message_valid  = 1'b0;
        req_ch.error_detected = 1'b0;
        req_ch.error_code     = ERR_NONE;
        rsp_ch.ready          = 1'b0;

        // shadow state matches the block after reset
        win_min = WIN_MIN_RST;
        win_max = WIN_MAX_RST;
        elapsed = '0;
        cooling = 1'b0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed ticks on the reset window
        push_tick(1'b1, 1'b0, ERR_NONE);       // heartbeat at count zero: early restart
        push_tick(1'b1, 1'b1, ERR_NONE);       // error flag with code none: no action
        push_tick(1'b1, 1'b1, ERR_OVERHEAT);   // cooling turns on
        push_tick(1'b1, 1'b1, ERR_OVERHEAT);   // overheat while cooling: fault restart
        push_tick(1'b1, 1'b1, ERR_TIMEOUT);
        push_tick(1'b1, 1'b1, ERR_UNKNOWN);
        push_tick(1'b0, 1'b1, ERR_UNKNOWN);    // error flag without a message is ignored
        push_tick(1'b1, 1'b1, ERR_OVERHEAT);   // cooling on again
        repeat (11) push_tick(1'b0, 1'b0, ERR_NONE);  // run past the maximum, cooling clears
        wait_idle();

        // minimum above maximum: timeout, early and fault all in one tick
        set_window('1, '0, 1'b1);
        push_tick(1'b1, 1'b1, ERR_TIMEOUT);
        push_tick(1'b1, 1'b1, ERR_UNKNOWN);
        wait_idle();

        // random phases across fixed extremes and random small windows,
        // one of them at full rate with no gaps and no stalls
        for (p = 0; p < 12; p++) begin
            case (p)
                0:  begin lo = WIN_MIN_RST; hi = WIN_MAX_RST; end
                1:  begin lo = '0;          hi = '0;          end
                2:  begin lo = 2;           hi = 8;           end
                3:  begin lo = 5;           hi = 5;           end
                4:  begin lo = '0;          hi = '1;          end
                5:  begin lo = 7;           hi = 3;           end
                6:  begin lo = 1;           hi = 1;           end
                7:  begin lo = '1;          hi = '1;          end
                8:  begin lo = 3;           hi = 20;          end
                default: begin
                    lo = WIN_WIDTH'($urandom_range(0, 8));
                    hi = WIN_WIDTH'($urandom_range(0, 24));
                end
            endcase
            full_rate = (p == 8);
            set_window(lo, hi, 1'($urandom));
            queue_heartbeat_runs(PHASE_TICKS);
            wait_idle();
        end
        full_rate = 1'b0;

        // let any stray result show up before judging
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
